// ----- design/cvo_pkg.sv -----
package cvo_pkg;

	// Result codes, in priority order of the tests.
	typedef enum logic [2:0] {
		WHY_CAVE     = 3'd0,
		WHY_DISABLED = 3'd1,
		WHY_BAND     = 3'd2,
		WHY_WATER    = 3'd3,
		WHY_FIELD    = 3'd4,
		WHY_TAPER    = 3'd5
	} why_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		CFG_ENABLE    = 3'd0,
		CFG_SEED      = 3'd1,
		CFG_INV_H     = 3'd2,
		CFG_INV_V     = 3'd3,
		CFG_MIN_DEPTH = 3'd4,
		CFG_MAX_DEPTH = 3'd5,
		CFG_WATER     = 3'd6,
		CFG_THRESHOLD = 3'd7
	} cfg_idx_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int INV_W      = 24;
	localparam int DEPTH_W    = 31;
	localparam int THR_W      = 17;
	localparam int EDGE_W     = 11;

	// Lattice hash multipliers.
	localparam logic [31:0] HASH_KX = 32'h9e3779b9;
	localparam logic [31:0] HASH_KY = 32'h85ebca6b;
	localparam logic [31:0] HASH_KZ = 32'hc2b2ae35;
	localparam logic [31:0] HASH_K1 = 32'h7feb352d;
	localparam logic [31:0] HASH_K2 = 32'h846ca68b;
	localparam logic [31:0] SEED_XOR = 32'h5bd1e995;

	// Second-field offsets in noise units with 32 fraction bits.
	localparam logic signed [39:0] OFS_X = 40'sd179100136243;
	localparam logic signed [39:0] OFS_Y = 40'sd56264071578;
	localparam logic signed [39:0] OFS_Z = 40'sd117252607181;

	// Full taper width, 4 m in Q24.8.
	localparam logic [EDGE_W-1:0] TAPER_FULL = 11'd1024;

	// Reset values of the configuration registers.
	localparam logic [INV_W-1:0]   RST_INV_H     = 24'd262144;
	localparam logic [INV_W-1:0]   RST_INV_V     = 24'd524288;
	localparam logic [DEPTH_W-1:0] RST_MIN_DEPTH = 31'd2048;
	localparam logic [DEPTH_W-1:0] RST_MAX_DEPTH = 31'd32768;
	localparam logic [31:0]        RST_WATER     = 32'hffffc000;
	localparam logic [THR_W-1:0]   RST_THRESHOLD = 17'd5243;

endpackage

// ----- design/cvo_ifs.sv -----
interface cvo_req_if #(parameter int POS_WIDTH = 32);
	logic                        valid;
	logic                        ready;
	logic signed [POS_WIDTH-1:0] pos_x;
	logic signed [POS_WIDTH-1:0] pos_y;
	logic signed [POS_WIDTH-1:0] pos_z;
	logic signed [POS_WIDTH-1:0] surface_height;

	modport source(output valid, pos_x, pos_y, pos_z, surface_height, input ready);
	modport sink(input valid, pos_x, pos_y, pos_z, surface_height, output ready);
endinterface

interface cvo_res_if;
	logic       valid;
	logic       ready;
	logic       is_cave;
	logic [2:0] why_solid;

	modport source(output valid, is_cave, why_solid, input ready);
	modport sink(input valid, is_cave, why_solid, output ready);
endinterface

// ----- design/cvo_hash.sv -----
module cvo_hash import cvo_pkg::*; #(
	parameter int F = 16
) (
	input  logic                clk,
	input  logic [2:0]          adv,
	input  logic [31:0]         ix,
	input  logic [31:0]         iy,
	input  logic [31:0]         iz,
	input  logic [31:0]         seed,
	output logic signed [F:0]   corner_val [8]
);

	logic [31:0] kx_s1, ky_s1, kz_s1;
	logic [31:0] h_s2 [8];
	logic [31:0] h_s3 [8];

	// Axis products; the upper lattice neighbor adds one multiplier more.
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			kx_s1 <= 32'(ix * HASH_KX);
			ky_s1 <= 32'(iy * HASH_KY);
			kz_s1 <= 32'(iz * HASH_KZ);
		end
	end

	// First mixing round for each of the eight corners.
	always_ff @(posedge clk) begin
		logic [31:0] h;
		if (adv[1]) begin
			for (int c = 0; c < 8; c++) begin
				h = seed ^ (c[0] ? kx_s1 + HASH_KX : kx_s1)
					^ (c[1] ? ky_s1 + HASH_KY : ky_s1)
					^ (c[2] ? kz_s1 + HASH_KZ : kz_s1);
				h = h ^ (h >> 16);
				h_s2[c] <= 32'(h * HASH_K1);
			end
		end
	end

	// Second mixing round.
	always_ff @(posedge clk) begin
		logic [31:0] h;
		if (adv[2]) begin
			for (int c = 0; c < 8; c++) begin
				h = h_s2[c] ^ (h_s2[c] >> 15);
				h_s3[c] <= 32'(h * HASH_K2);
			end
		end
	end

	// Final shift, then the top bits as a signed value in [-1, 1).
	always_comb begin
		logic [31:0] h;
		for (int c = 0; c < 8; c++) begin
			h = h_s3[c] ^ (h_s3[c] >> 16);
			corner_val[c] = signed'({~h[31], h[30:31-F]});
		end
	end

endmodule

// ----- design/cvo_smooth.sv -----
module cvo_smooth #(
	parameter int F = 16
) (
	input  logic         clk,
	input  logic [2:0]   adv,
	input  logic [F-1:0] t,
	output logic [F:0]   w
);

	logic [F-1:0] t_s1, s_s1, c_s2;
	logic [F+5:0] p_s2;
	logic [F:0]   w_s3;

	// Square of the fraction.
	always_ff @(posedge clk) begin
		logic [2*F-1:0] sq;
		if (adv[0]) begin
			sq = t * t;
			t_s1 <= t;
			s_s1 <= sq[2*F-1:F];
		end
	end

	// Cube and the polynomial 6s - 15t + 10.
	always_ff @(posedge clk) begin
		logic [2*F-1:0] cu;
		if (adv[1]) begin
			cu = s_s1 * t_s1;
			c_s2 <= cu[2*F-1:F];
			p_s2 <= (F+6)'(s_s1) * (F+6)'(6) + ((F+6)'(10) << F)
				- (F+6)'(t_s1) * (F+6)'(15);
		end
	end

	// Weight c * p.
	always_ff @(posedge clk) begin
		logic [2*F+5:0] pr;
		if (adv[2]) begin
			pr = (2*F+6)'(c_s2) * (2*F+6)'(p_s2);
			w_s3 <= pr[2*F:F];
		end
	end

	assign w = w_s3;

endmodule

// ----- design/cvo_noise.sv -----
module cvo_noise import cvo_pkg::*; #(
	parameter int CW = 58,
	parameter int F  = 16
) (
	input  logic                 clk,
	input  logic [5:0]           adv,
	input  logic signed [CW-1:0] coord_x,
	input  logic signed [CW-1:0] coord_y,
	input  logic signed [CW-1:0] coord_z,
	input  logic [31:0]          seed,
	output logic signed [F+1:0]  noise_val
);

	localparam int LW = F + 2;

	logic signed [CW-1:0] sx, sy, sz;
	logic signed [F:0]    cval [8];
	logic [F:0]           wx, wy, wz;
	logic [F:0]           wy_s6, wz_s6, wz_s7;
	logic signed [LW-1:0] l1_s6 [4];
	logic signed [LW-1:0] l2_s7 [2];
	logic signed [LW-1:0] n_s8;

	function automatic logic signed [LW-1:0] lerp(input logic signed [LW-1:0] a,
		input logic signed [LW-1:0] b, input logic [F:0] wt);
		logic signed [LW:0]     d;
		logic signed [LW+F+1:0] p;
		d = (LW+1)'(b) - (LW+1)'(a);
		p = d * signed'({1'b0, wt});
		lerp = a + LW'(p >>> F);
	endfunction

	// Lattice index is the integer part, weight input the top fraction bits.
	assign sx = coord_x >>> 32;
	assign sy = coord_y >>> 32;
	assign sz = coord_z >>> 32;

	cvo_hash #(.F(F)) u_hash (
		.clk(clk), .adv(adv[2:0]),
		.ix(sx[31:0]), .iy(sy[31:0]), .iz(sz[31:0]),
		.seed(seed), .corner_val(cval)
	);

	cvo_smooth #(.F(F)) u_smx (.clk(clk), .adv(adv[2:0]), .t(coord_x[31:32-F]), .w(wx));
	cvo_smooth #(.F(F)) u_smy (.clk(clk), .adv(adv[2:0]), .t(coord_y[31:32-F]), .w(wy));
	cvo_smooth #(.F(F)) u_smz (.clk(clk), .adv(adv[2:0]), .t(coord_z[31:32-F]), .w(wz));

	// Interpolate along x.
	always_ff @(posedge clk) begin
		if (adv[3]) begin
			for (int k = 0; k < 4; k++)
				l1_s6[k] <= lerp(LW'(cval[2*k]), LW'(cval[2*k+1]), wx);
			wy_s6 <= wy;
			wz_s6 <= wz;
		end
	end

	// Interpolate along y.
	always_ff @(posedge clk) begin
		if (adv[4]) begin
			for (int k = 0; k < 2; k++)
				l2_s7[k] <= lerp(l1_s6[2*k], l1_s6[2*k+1], wy_s6);
			wz_s7 <= wz_s6;
		end
	end

	// Interpolate along z.
	always_ff @(posedge clk) begin
		if (adv[5]) begin
			n_s8 <= lerp(l2_s7[0], l2_s7[1], wz_s7);
		end
	end

	assign noise_val = n_s8;

endmodule

// ----- design/cave_voxel_occupancy_test_core.sv -----
// Throughput: one request per cycle while vox_res.ready is high; every stage holds its own
// valid bit, so a stalled output fills empty stages first and input ready drops only when
// all nine stages are full.
// The depth is set by the hash chain and the three interpolation levels, one multiply each.
// Reset (arst_n low, asynchronous) empties the pipeline and loads the register defaults.
module cave_voxel_occupancy_test_core import cvo_pkg::*; #(
	parameter int POS_WIDTH       = 32,
	parameter int NOISE_FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	cvo_req_if.sink               vox_req,
	cvo_res_if.source             vox_res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int F    = NOISE_FRAC_BITS;
	localparam int PW   = POS_WIDTH;
	localparam int HALF = PW / 2;
	localparam int HI   = PW - HALF;
	localparam int CW   = PW + 26;
	localparam int DW   = ((PW + 1 > 32) ? PW + 1 : 32) + 1;
	localparam int WW   = (PW > 32) ? PW : 32;
	localparam int CMPW = F + 30;

	// Configuration registers.
	logic                enable_q;
	logic [31:0]         seed_q;
	logic [INV_W-1:0]    inv_h_q, inv_v_q;
	logic [DEPTH_W-1:0]  min_depth_q, max_depth_q;
	logic [31:0]         water_q;
	logic [THR_W-1:0]    thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b0;
			seed_q      <= '0;
			inv_h_q     <= RST_INV_H;
			inv_v_q     <= RST_INV_V;
			min_depth_q <= RST_MIN_DEPTH;
			max_depth_q <= RST_MAX_DEPTH;
			water_q     <= RST_WATER;
			thr_q       <= RST_THRESHOLD;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ENABLE:    enable_q    <= cfg_wdata[0];
				CFG_SEED:      seed_q      <= cfg_wdata;
				CFG_INV_H:     inv_h_q     <= cfg_wdata[INV_W-1:0];
				CFG_INV_V:     inv_v_q     <= cfg_wdata[INV_W-1:0];
				CFG_MIN_DEPTH: min_depth_q <= cfg_wdata[DEPTH_W-1:0];
				CFG_MAX_DEPTH: max_depth_q <= cfg_wdata[DEPTH_W-1:0];
				CFG_WATER:     water_q     <= cfg_wdata;
				CFG_THRESHOLD: thr_q       <= cfg_wdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// Valid bits and per-stage ready.
	logic [9:1]  v_q;
	logic [10:1] rdy;

	always_comb begin
		rdy[10] = vox_res.ready;
		for (int k = 9; k >= 1; k--)
			rdy[k] = !v_q[k] || rdy[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		logic [9:1] vin;
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			vin = {v_q[8:1], vox_req.valid};
			for (int k = 1; k <= 9; k++)
				if (rdy[k])
					v_q[k] <= vin[k];
		end
	end

	assign vox_req.ready = rdy[1];

	// Stage 1: depth, early tests and partial coordinate products.
	logic signed [DW-1:0]   depth_c, depth_s1;
	logic signed [WW-1:0]   py_w, water_w;
	logic                   band_out, below_water;
	why_t                   why_c, why_s1, why_s2, why_s3, why_s4, why_s5, why_s6;
	why_t                   why_s7, why_s8, why_s9;
	logic [HALF+INV_W-1:0]  xl_s1, yl_s1, zl_s1;
	logic signed [HI+INV_W:0] xh_s1, yh_s1, zh_s1;
	logic signed [INV_W:0]  inv_h_sg, inv_v_sg;

	assign depth_c     = DW'(vox_req.surface_height) - DW'(vox_req.pos_y);
	assign band_out    = (depth_c < signed'(DW'(min_depth_q)))
		|| (depth_c > signed'(DW'(max_depth_q)));
	assign py_w        = WW'(vox_req.pos_y);
	assign water_w     = WW'(signed'(water_q));
	assign below_water = py_w <= water_w;
	assign inv_h_sg    = signed'({1'b0, inv_h_q});
	assign inv_v_sg    = signed'({1'b0, inv_v_q});

	always_comb begin
		if (!enable_q)
			why_c = WHY_DISABLED;
		else if (band_out)
			why_c = WHY_BAND;
		else if (below_water)
			why_c = WHY_WATER;
		else
			why_c = WHY_CAVE;
	end

	always_ff @(posedge clk) begin
		logic signed [HI-1:0] hx, hy, hz;
		if (rdy[1]) begin
			hx = vox_req.pos_x[PW-1:HALF];
			hy = vox_req.pos_y[PW-1:HALF];
			hz = vox_req.pos_z[PW-1:HALF];
			why_s1   <= why_c;
			depth_s1 <= depth_c;
			xl_s1    <= vox_req.pos_x[HALF-1:0] * inv_h_q;
			yl_s1    <= vox_req.pos_y[HALF-1:0] * inv_v_q;
			zl_s1    <= vox_req.pos_z[HALF-1:0] * inv_h_q;
			xh_s1    <= hx * inv_h_sg;
			yh_s1    <= hy * inv_v_sg;
			zh_s1    <= hz * inv_h_sg;
		end
	end

	// Stage 2: full coordinates of both fields and the distance to the band edge.
	logic signed [CW-1:0] ax_s2, ay_s2, az_s2, bx_s2, by_s2, bz_s2;
	logic [EDGE_W-1:0]    edge_s2;

	always_ff @(posedge clk) begin
		logic signed [CW-1:0] cx, cy, cz;
		logic signed [DW-1:0] e1, e2, em;
		if (rdy[2]) begin
			cx = (CW'(xh_s1) <<< HALF) + signed'(CW'(xl_s1));
			cy = (CW'(yh_s1) <<< HALF) + signed'(CW'(yl_s1));
			cz = (CW'(zh_s1) <<< HALF) + signed'(CW'(zl_s1));
			ax_s2 <= cx;
			ay_s2 <= cy;
			az_s2 <= cz;
			bx_s2 <= cx + CW'(OFS_X);
			by_s2 <= cy + CW'(OFS_Y);
			bz_s2 <= cz - CW'(OFS_Z);
			e1 = depth_s1 - signed'(DW'(min_depth_q));
			e2 = signed'(DW'(max_depth_q)) - depth_s1;
			em = (e2 < e1) ? e2 : e1;
			edge_s2 <= (em > signed'(DW'(TAPER_FULL))) ? TAPER_FULL : em[EDGE_W-1:0];
			why_s2 <= why_s1;
		end
	end

	// Stage 3: tapered threshold; later stages carry the early result along.
	logic [THR_W+EDGE_W-1:0] tp_s3, tp_s4, tp_s5, tp_s6, tp_s7, tp_s8;

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			tp_s3  <= thr_q * edge_s2;
			why_s3 <= why_s2;
		end
		if (rdy[4]) begin
			tp_s4  <= tp_s3;
			why_s4 <= why_s3;
		end
		if (rdy[5]) begin
			tp_s5  <= tp_s4;
			why_s5 <= why_s4;
		end
		if (rdy[6]) begin
			tp_s6  <= tp_s5;
			why_s6 <= why_s5;
		end
		if (rdy[7]) begin
			tp_s7  <= tp_s6;
			why_s7 <= why_s6;
		end
		if (rdy[8]) begin
			tp_s8  <= tp_s7;
			why_s8 <= why_s7;
		end
	end

	// Stages 3 to 8: the two noise fields.
	logic signed [F+1:0] na, nb;

	cvo_noise #(.CW(CW), .F(F)) u_noise_a (
		.clk(clk), .adv(rdy[8:3]),
		.coord_x(ax_s2), .coord_y(ay_s2), .coord_z(az_s2),
		.seed(seed_q), .noise_val(na)
	);

	cvo_noise #(.CW(CW), .F(F)) u_noise_b (
		.clk(clk), .adv(rdy[8:3]),
		.coord_x(bx_s2), .coord_y(by_s2), .coord_z(bz_s2),
		.seed(seed_q ^ SEED_XOR), .noise_val(nb)
	);

	// Stage 9: threshold and taper tests, result register.
	always_ff @(posedge clk) begin
		logic [F+1:0]    aa, ab;
		logic [CMPW-1:0] lim, tlim;
		if (rdy[9]) begin
			aa   = na[F+1] ? (F+2)'(-na) : (F+2)'(na);
			ab   = nb[F+1] ? (F+2)'(-nb) : (F+2)'(nb);
			lim  = CMPW'(thr_q) << F;
			tlim = CMPW'(tp_s8) << F;
			if (why_s8 != WHY_CAVE)
				why_s9 <= why_s8;
			else if ((CMPW'(aa) << 16) > lim || (CMPW'(ab) << 16) > lim)
				why_s9 <= WHY_FIELD;
			else if ((CMPW'(aa) << 26) > tlim || (CMPW'(ab) << 26) > tlim)
				why_s9 <= WHY_TAPER;
			else
				why_s9 <= WHY_CAVE;
		end
	end

	assign vox_res.valid     = v_q[9];
	assign vox_res.is_cave   = (why_s9 == WHY_CAVE);
	assign vox_res.why_solid = why_s9;

	// Input ready falls only when every stage holds a request.
	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!rdy[1] |-> (&v_q))
		else $error("input blocked with an empty stage");

	// A blocked middle stage keeps its request.
	a_mid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[5] && !rdy[5] |=> v_q[5])
		else $error("request lost in a stalled stage");

	// An early failing test survives to the result.
	a_early_reason: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[8] && rdy[9] && why_s8 != WHY_CAVE |=> why_s9 == $past(why_s8))
		else $error("early result code overwritten");

endmodule
